/* rtl/core/sqnsg_pkg.sv */
package sqnsg_pkg;

	localparam int unsigned FULL_SCALE = 8000;

	localparam int unsigned NUM_CH    = 4;
	localparam int unsigned DIV_W     = 10;
	localparam int unsigned LEVEL_W   = 13;
	localparam int unsigned LFSR_W    = 16;
	localparam int unsigned SAMPLE_W  = 15;
	localparam int unsigned SUM_W     = 17;

	localparam logic [LFSR_W-1:0] LFSR_SEED = 16'h8000;
	localparam logic [1:0]        NOISE_CH  = 2'd3;

	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_WRITE = 1'b1
	} op_t;

	typedef logic [DIV_W-1:0]   div_t;
	typedef logic [LEVEL_W-1:0] level_t;
	typedef level_t             rom_t [16];

	// one processed item, handed from the input register to the datapath
	typedef struct packed {
		logic       tick;
		logic       write;
		logic [7:0] data;
	} step_t;

	// FULL_SCALE * 10^(-i/10) for i below 15, zero for i = 15; Q32 scale factors rounded up, then truncated
	function automatic rom_t build_atten_rom();
		logic [63:0] k;
		logic [63:0] p;
		rom_t        r;
		for (int i = 0; i < 16; i++) begin
			unique case (i)
				0:       k = 64'd4294967296;
				1:       k = 64'd3411613791;
				2:       k = 64'd2709941160;
				3:       k = 64'd2152582778;
				4:       k = 64'd1709857278;
				5:       k = 64'd1358187914;
				6:       k = 64'd1078847008;
				7:       k = 64'd856958639;
				8:       k = 64'd680706443;
				9:       k = 64'd540704348;
				10:      k = 64'd429496730;
				11:      k = 64'd341161380;
				12:      k = 64'd270994116;
				13:      k = 64'd215258278;
				14:      k = 64'd170985728;
				default: k = 64'd0;
			endcase
			p = 64'(FULL_SCALE) * k;
			r[i] = p[44:32];
		end
		return r;
	endfunction

	localparam rom_t ATTEN_ROM = build_atten_rom();

endpackage

/* rtl/core/sqnsg_regs.sv */
module sqnsg_regs
	import sqnsg_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  step_t  step,
	output div_t   tone_divider [NUM_CH],
	output level_t channel_level [NUM_CH]
);

	logic [1:0] latched_ch_q;
	logic       latched_vol_q;
	div_t       divider_q [NUM_CH];
	level_t     level_q [NUM_CH];

	logic       first;
	logic [1:0] ch;
	logic       vol;

	assign first = step.data[7];
	assign ch    = first ? step.data[6:5] : latched_ch_q;
	assign vol   = first ? step.data[4] : latched_vol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latched_ch_q  <= '0;
			latched_vol_q <= 1'b0;
			for (int i = 0; i < NUM_CH; i++) begin
				divider_q[i] <= '0;
				level_q[i]   <= '0;
			end
		end else if (step.write) begin
			latched_ch_q  <= ch;
			latched_vol_q <= vol;
			if (vol) begin
				level_q[ch] <= ATTEN_ROM[step.data[3:0]];
			end else if (ch == NOISE_CH) begin
				divider_q[ch] <= div_t'(32) << step.data[1:0];
			end else if (first) begin
				divider_q[ch][3:0] <= step.data[3:0];
			end else begin
				divider_q[ch][9:4] <= step.data[5:0];
			end
		end
	end

	assign tone_divider  = divider_q;
	assign channel_level = level_q;

endmodule

/* rtl/core/sqnsg_osc.sv */
module sqnsg_osc
	import sqnsg_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tick,
	input  div_t                tone_divider [NUM_CH],
	input  level_t              channel_level [NUM_CH],
	output logic [SAMPLE_W-1:0] sample
);

	div_t              cnt_q [NUM_CH];
	logic [NUM_CH-1:0] pol_q;
	logic [LFSR_W-1:0] lfsr_q;
	logic [SAMPLE_W-1:0] sample_q;

	div_t                cnt_d [NUM_CH];
	logic [NUM_CH-1:0]   pol_d;
	logic [LFSR_W-1:0]   lfsr_d;
	logic signed [SUM_W-1:0] sum;

	always_comb begin
		lfsr_d = lfsr_q;
		if (cnt_q[3] == '0) begin
			lfsr_d = {lfsr_q[0] ^ lfsr_q[3], lfsr_q[LFSR_W-1:1]};
		end
		for (int i = 0; i < 3; i++) begin
			pol_d[i] = pol_q[i] ^ (cnt_q[i] == '0);
		end
		pol_d[3] = pol_q[3] ^ lfsr_d[0];
		for (int i = 0; i < NUM_CH; i++) begin
			cnt_d[i] = (cnt_q[i] == '0) ? tone_divider[i] : cnt_q[i] - div_t'(1);
		end
		sum = '0;
		for (int i = 0; i < NUM_CH; i++) begin
			if (pol_d[i]) begin
				sum = sum + $signed({4'b0, channel_level[i]});
			end else begin
				sum = sum - $signed({4'b0, channel_level[i]});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pol_q  <= '0;
			lfsr_q <= LFSR_SEED;
			for (int i = 0; i < NUM_CH; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (tick) begin
			pol_q  <= pol_d;
			lfsr_q <= lfsr_d;
			cnt_q  <= cnt_d;
		end
	end

	// floor(sum / 2); |sum| stays within 16 bits
	always_ff @(posedge clk) begin
		if (tick) begin
			sample_q <= sum[SAMPLE_W:1];
		end
	end

	assign sample = sample_q;

endmodule

/* rtl/core/square_noise_sound_generator_core.sv */
// Four-channel square and noise sound generator. Each input transfer is either one
// register write byte (tuser = 1) or one chip clock tick (tuser = 0); every tick
// yields one signed 15-bit sample, writes yield nothing. A transfer is registered,
// then processed from that register: a write updates the channel registers, and a
// tick steps the tone and noise counters, the noise LFSR and the mixer, with the
// sample held in an output register. One transfer is taken every cycle; the input
// register stalls only when a tick meets a sample still waiting downstream. A tick
// passes the input register, then the output register, which holds its sample
// until it is taken. The attenuation table is fixed at a full scale of 8000.
module square_noise_sound_generator_core
	import sqnsg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic [0:0]  s_axis_tuser,  // [0] operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // [14:0] sample, [15] zero
);

	logic       in_valid_s1;
	op_t        in_op_s1;
	logic [7:0] in_byte_s1;
	logic       out_valid_q;

	logic       process;
	step_t      step;
	div_t       tone_divider [NUM_CH];
	level_t     channel_level [NUM_CH];
	logic [SAMPLE_W-1:0] sample;

	assign process = in_valid_s1 && (in_op_s1 == OP_WRITE || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !in_valid_s1 || process;

	assign step.tick  = process && (in_op_s1 == OP_TICK);
	assign step.write = process && (in_op_s1 == OP_WRITE);
	assign step.data  = in_byte_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			in_op_s1    <= OP_TICK;
			in_byte_s1  <= '0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			in_valid_s1 <= 1'b1;
			in_op_s1    <= op_t'(s_axis_tuser[0]);
			in_byte_s1  <= s_axis_tdata;
		end else if (process) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step.tick) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	sqnsg_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.tone_divider  (tone_divider),
		.channel_level (channel_level)
	);

	sqnsg_osc u_osc (
		.clk           (clk),
		.arst_n        (arst_n),
		.tick          (step.tick),
		.tone_divider  (tone_divider),
		.channel_level (channel_level),
		.sample        (sample)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, sample};

	// a tick never overwrites a sample that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(step.tick && out_valid_q && !m_axis_tready))
		else $error("tick processed over a pending sample");

	a_tick_gives_sample: assert property (@(posedge clk) disable iff (!arst_n)
		step.tick |=> m_axis_tvalid)
		else $error("processed tick gave no sample");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (in_valid_s1 && in_op_s1 == OP_TICK && out_valid_q))
		else $error("input stalled without cause");

	a_write_no_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid_q && !step.tick) |=> !m_axis_tvalid)
		else $error("sample appeared without a tick");

endmodule
